>>> rtl/core/akhv_pkg.sv
// Shared types and constants of the analog key hysteresis and velocity block.
package akhv_pkg;

  localparam int KEYS   = 128;
  localparam int WINDOW = 5;
  localparam int KEY_W  = 7;
  localparam int SMP_W  = 13;
  localparam int TH_W   = 12;
  localparam int VEL_W  = 17;
  localparam int CNT_W  = 16;
  localparam int SLOT_W = 3;
  localparam int DLY_W  = 5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 1'b1;

  localparam logic [TH_W-1:0] PRESS_RESET   = 12'd2048;
  localparam logic [TH_W-1:0] RELEASE_RESET = 12'd2400;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Velocity scaling: v = round(S * 2^17 / 3375) for 0 < S < 1688, else saturate.
  localparam logic [VEL_W-1:0] VEL_FULL    = 17'h10000;
  localparam logic [15:0]      VEL_SAT_SUM = 16'd1688;
  localparam logic [27:0]      VEL_HALF    = 28'd1687;
  // ceil(2^40 / 3375); exact floor division for every dividend below 2^28
  localparam logic [28:0]      VEL_RECIP   = 29'd325781224;
  localparam int               VEL_SHIFT   = 40;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key_index;
    logic [SMP_W-1:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic             is_down;
    logic             edge_res;
    logic [VEL_W-1:0] velocity;
    logic             velocity_fresh;
    logic [CNT_W-1:0] capture_count;
  } result_item_t;

endpackage

>>> rtl/core/analog_key_hysteresis_velocity.sv
// Top level: per-key press/release hysteresis and press velocity capture.
//
// Pipeline: a result passes one key record read-modify-write stage, three
// velocity fit stages and one scale stage with the velocity store read, and
// is held in an output register.
// Throughput: one item per cycle, any key order; the key record store and the
// velocity store each forward their last write, so back-to-back items on the
// same key need no interlock. Stalls come only from the result side.
// Reset: synchronous; thresholds return to 2048/2400, all per-key state reads
// as zero through valid bits until written, the sample window included.
module analog_key_hysteresis_velocity (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  akhv_pkg::sample_item_t        sample_item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output akhv_pkg::result_item_t        result_item,
  input  logic                          cfg_write,
  input  logic [akhv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [akhv_pkg::TH_W-1:0]     cfg_wdata
);

  // Per-key record: control state plus the five-slot sample window.
  typedef struct packed {
    logic                                    down;
    logic                                    rearm;
    logic [akhv_pkg::DLY_W-1:0]              delay;
    logic [akhv_pkg::SLOT_W-1:0]             slot;
    logic [akhv_pkg::CNT_W-1:0]              count;
    logic [akhv_pkg::WINDOW-1:0][akhv_pkg::SMP_W-1:0] win;
  } key_rec_t;

  // Item attributes that ride alongside the velocity fit.
  typedef struct packed {
    logic [akhv_pkg::KEY_W-1:0] key;
    logic                       clear;
    logic                       key_ok;
    logic                       down;
    logic                       edge_chg;
    logic                       fresh;
    logic [akhv_pkg::CNT_W-1:0] count;
  } side_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [akhv_pkg::TH_W-1:0] press_threshold;
  logic [akhv_pkg::TH_W-1:0] release_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold   <= akhv_pkg::PRESS_RESET;
      release_threshold <= akhv_pkg::RELEASE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        akhv_pkg::REG_PRESS:   press_threshold   <= cfg_wdata;
        akhv_pkg::REG_RELEASE: release_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage flow: each stage loads when it is empty or its successor moves.
  // ---------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic out_free, s5_free, s4_free, s3_free, s2_free, s1_free;

  assign out_free = !result_valid || result_ready;
  assign s5_free  = !s5_valid || out_free;
  assign s4_free  = !s4_valid || s5_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;

  assign sample_ready = s1_free;

  logic take_in, s1_exit, s5_exit;
  assign take_in = sample_valid && s1_free;
  assign s1_exit = s1_valid && s2_free;
  assign s5_exit = s5_valid && out_free;

  // ---------------------------------------------------------------------
  // Key record store: read on transfer, written when the item leaves stage 1
  // ---------------------------------------------------------------------
  key_rec_t                  rec_mem [akhv_pkg::KEYS];
  logic [akhv_pkg::KEYS-1:0] rec_vld;
  key_rec_t                  rec_rd;
  logic                      rec_rd_vb;

  logic                       s1_op;
  logic [akhv_pkg::KEY_W-1:0] s1_key;
  logic [akhv_pkg::SMP_W-1:0] s1_smp;

  // Last record written, for the item that read the store in the same cycle.
  logic                       lw_valid;
  logic [akhv_pkg::KEY_W-1:0] lw_key;
  key_rec_t                   lw_rec;

  key_rec_t rec_new;
  logic     rec_we;

  always_ff @(posedge clk) begin
    if (take_in) begin
      rec_rd <= rec_mem[sample_item.key_index];
    end
    if (rec_we) begin
      rec_mem[s1_key] <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld   <= '0;
      rec_rd_vb <= 1'b0;
      lw_valid  <= 1'b0;
    end else begin
      if (take_in) begin
        rec_rd_vb <= rec_vld[sample_item.key_index];
      end
      if (rec_we) begin
        rec_vld[s1_key] <= 1'b1;
        lw_valid        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      lw_key <= s1_key;
      lw_rec <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_op  <= sample_item.op;
      s1_key <= sample_item.key_index;
      s1_smp <= sample_item.sample;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: hysteresis, arming, delay line, window insert
  // ---------------------------------------------------------------------
  key_rec_t                   cur;
  logic                       s1_key_ok, s1_clear;
  logic                       was, nxt, trig, rel, fire, rearm_mid;
  logic [akhv_pkg::SLOT_W-1:0] w_cur, w_nxt;
  logic [akhv_pkg::WINDOW-1:0][akhv_pkg::SMP_W-1:0] win_new;
  logic [akhv_pkg::WINDOW-1:0][akhv_pkg::SMP_W-1:0] ordered;
  side_t                      s1_side;

  assign s1_key_ok = 32'(s1_key) < akhv_pkg::KEYS;
  assign s1_clear  = (s1_op == akhv_pkg::OP_CLEAR);

  always_comb begin
    if (lw_valid && lw_key == s1_key) begin
      cur = lw_rec;
    end else if (rec_rd_vb) begin
      cur = rec_rd;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    logic [akhv_pkg::SLOT_W:0] idx;
    was  = cur.down;
    nxt  = was ? ({1'b0, release_threshold} >= s1_smp)
               : (s1_smp < {1'b0, press_threshold});
    trig = nxt && !was;
    rel  = s1_smp > {1'b0, release_threshold};
    fire = cur.delay[akhv_pkg::DLY_W-1];

    // fold the slot into range, then advance it around the window
    w_cur = (cur.slot >= akhv_pkg::SLOT_W'(akhv_pkg::WINDOW))
          ? cur.slot - akhv_pkg::SLOT_W'(akhv_pkg::WINDOW) : cur.slot;
    w_nxt = (w_cur == akhv_pkg::SLOT_W'(akhv_pkg::WINDOW - 1))
          ? '0 : w_cur + 1'b1;

    win_new        = cur.win;
    win_new[w_cur] = s1_smp;

    // oldest sample sits at the slot written next
    for (int i = 0; i < akhv_pkg::WINDOW; i++) begin
      idx = {1'b0, w_nxt} + (akhv_pkg::SLOT_W + 1)'(i);
      if (idx >= (akhv_pkg::SLOT_W + 1)'(akhv_pkg::WINDOW)) begin
        idx = idx - (akhv_pkg::SLOT_W + 1)'(akhv_pkg::WINDOW);
      end
      ordered[i] = win_new[idx[akhv_pkg::SLOT_W-1:0]];
    end

    rearm_mid = cur.rearm || rel;

    rec_new = cur;
    if (s1_clear) begin
      // clear keeps the window and the capture count
      rec_new.down  = 1'b0;
      rec_new.rearm = 1'b0;
      rec_new.delay = '0;
      rec_new.slot  = '0;
    end else begin
      rec_new.down  = nxt;
      rec_new.win   = win_new;
      rec_new.slot  = w_nxt;
      rec_new.count = cur.count + akhv_pkg::CNT_W'(fire);
      rec_new.delay = {cur.delay[akhv_pkg::DLY_W-2:0], 1'b0};
      rec_new.rearm = rearm_mid;
      if (trig && rearm_mid) begin
        rec_new.delay[0] = 1'b1;
        rec_new.rearm    = 1'b0;
      end
    end

    s1_side          = '0;
    s1_side.key      = s1_key;
    s1_side.clear    = s1_clear;
    s1_side.key_ok   = s1_key_ok;
    if (s1_key_ok) begin
      s1_side.count = rec_new.count;
      if (!s1_clear) begin
        s1_side.down     = nxt;
        s1_side.edge_chg = nxt != was;
        s1_side.fresh    = fire;
      end
    end
  end

  assign rec_we = s1_exit && s1_key_ok;

  // ---------------------------------------------------------------------
  // Stage 2: intervals (older minus newer) and their total
  // ---------------------------------------------------------------------
  side_t s2_side;
  logic [akhv_pkg::WINDOW-1:0][akhv_pkg::SMP_W-1:0] s2_smp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_exit) begin
      s2_side <= s1_side;
      s2_smp  <= ordered;
    end
  end

  logic signed [13:0] d2 [4];
  logic signed [15:0] tot2;

  always_comb begin
    tot2 = '0;
    for (int i = 0; i < 4; i++) begin
      d2[i] = $signed({1'b0, s2_smp[i]}) - $signed({1'b0, s2_smp[i+1]});
      tot2  = tot2 + 16'(d2[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: median pair sum = total minus the extremes
  // ---------------------------------------------------------------------
  side_t              s3_side;
  logic signed [13:0] s3_d [4];
  logic signed [15:0] s3_tot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_free) begin
      s3_side <= s2_side;
      s3_d    <= d2;
      s3_tot  <= tot2;
    end
  end

  logic signed [13:0] mn_a, mn_b, mx_a, mx_b, mn3, mx3;
  logic signed [15:0] mid3;

  always_comb begin
    mn_a = (s3_d[0] < s3_d[1]) ? s3_d[0] : s3_d[1];
    mx_a = (s3_d[0] < s3_d[1]) ? s3_d[1] : s3_d[0];
    mn_b = (s3_d[2] < s3_d[3]) ? s3_d[2] : s3_d[3];
    mx_b = (s3_d[2] < s3_d[3]) ? s3_d[3] : s3_d[2];
    mn3  = (mn_a < mn_b) ? mn_a : mn_b;
    mx3  = (mx_a < mx_b) ? mx_b : mx_a;
    mid3 = s3_tot - 16'(mn3) - 16'(mx3);
  end

  // ---------------------------------------------------------------------
  // Stage 4: drop the interval furthest from the median, earliest on ties
  // ---------------------------------------------------------------------
  side_t              s4_side;
  logic signed [13:0] s4_d [4];
  logic signed [15:0] s4_tot;
  logic signed [15:0] s4_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_free) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s4_free) begin
      s4_side <= s3_side;
      s4_d    <= s3_d;
      s4_tot  <= s3_tot;
      s4_mid  <= mid3;
    end
  end

  logic signed [15:0] kept4;

  always_comb begin
    logic signed [16:0] spread;
    logic signed [16:0] best;
    logic        [1:0]  drop;
    best = -17'sd1;
    drop = '0;
    for (int i = 0; i < 4; i++) begin
      spread = 17'(s4_d[i]) * 17'sd2 - 17'(s4_mid);
      if (spread < 0) begin
        spread = -spread;
      end
      if (spread > best) begin
        best = spread;
        drop = 2'(i);
      end
    end
    kept4 = s4_tot - 16'(s4_d[drop]);
  end

  // ---------------------------------------------------------------------
  // Stage 5: scale to Q1.16, merge with the stored velocity
  // ---------------------------------------------------------------------
  side_t              s5_side;
  logic signed [15:0] s5_kept;

  logic [akhv_pkg::VEL_W-1:0] vel_mem [akhv_pkg::KEYS];
  logic [akhv_pkg::KEYS-1:0]  vel_vld;
  logic [akhv_pkg::VEL_W-1:0] vel_rd;
  logic                       vel_rd_vb;

  logic                       vfw_valid;
  logic [akhv_pkg::KEY_W-1:0] vfw_key;
  logic [akhv_pkg::VEL_W-1:0] vfw_val;

  logic [akhv_pkg::VEL_W-1:0] vel_out;
  logic                       vel_we;
  logic                       s4_load;

  assign s4_load = s4_valid && s5_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_free) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      s5_side <= s4_side;
      s5_kept <= kept4;
      vel_rd  <= vel_mem[s4_side.key];
    end
    if (vel_we) begin
      vel_mem[s5_side.key] <= vel_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_vld   <= '0;
      vel_rd_vb <= 1'b0;
      vfw_valid <= 1'b0;
    end else begin
      if (s4_load) begin
        vel_rd_vb <= vel_vld[s4_side.key];
      end
      if (vel_we) begin
        vel_vld[s5_side.key] <= 1'b1;
        vfw_valid            <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vfw_key <= s5_side.key;
      vfw_val <= vel_out;
    end
  end

  logic [27:0]                dividend;
  logic [56:0]                prod;
  logic [akhv_pkg::VEL_W-1:0] vel_calc;
  logic [akhv_pkg::VEL_W-1:0] vel_stored;

  always_comb begin
    dividend = {s5_kept[10:0], 17'd0} + akhv_pkg::VEL_HALF;
    prod     = 57'(dividend) * 57'(akhv_pkg::VEL_RECIP);
    if (s5_kept <= 16'sd0) begin
      vel_calc = '0;
    end else if (s5_kept >= $signed(akhv_pkg::VEL_SAT_SUM)) begin
      vel_calc = akhv_pkg::VEL_FULL;
    end else begin
      vel_calc = prod[akhv_pkg::VEL_SHIFT +: akhv_pkg::VEL_W];
    end

    if (vfw_valid && vfw_key == s5_side.key) begin
      vel_stored = vfw_val;
    end else if (vel_rd_vb) begin
      vel_stored = vel_rd;
    end else begin
      vel_stored = '0;
    end

    if (!s5_side.key_ok || s5_side.clear) begin
      vel_out = '0;
    end else if (s5_side.fresh) begin
      vel_out = vel_calc;
    end else begin
      vel_out = vel_stored;
    end
  end

  // write on a fresh capture, and zero the value on clear
  assign vel_we = s5_exit && s5_side.key_ok && (s5_side.clear || s5_side.fresh);

  // ---------------------------------------------------------------------
  // Output register: hold the result until its transfer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s5_exit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_exit) begin
      result_item.key_out        <= s5_side.key;
      result_item.is_down        <= s5_side.down;
      result_item.edge_res       <= s5_side.edge_chg;
      result_item.velocity       <= vel_out;
      result_item.velocity_fresh <= s5_side.fresh;
      result_item.capture_count  <= s5_side.count;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !s1_valid && !s5_valid)
    else $error("pipeline not empty after reset");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> cur.slot < akhv_pkg::SLOT_W'(akhv_pkg::WINDOW))
    else $error("window slot out of range");

  a_fwd_marked: assert property (@(posedge clk) disable iff (rst)
    lw_valid |-> rec_vld[lw_key])
    else $error("forwarded key record not marked written");

  a_vel_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.velocity <= akhv_pkg::VEL_FULL)
    else $error("velocity above full scale");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    s5_valid && s5_side.clear |-> !s5_side.fresh && !s5_side.down && !s5_side.edge_chg)
    else $error("clear result carries key activity");

endmodule
